### rtl/ptc_pkg.sv
// Package: shared types, constants and helpers of the pressure and temperature compensation core.
`timescale 1ns / 1ps
package ptc_pkg;

   localparam int ADC_W    = 20;
   localparam int WORD_W   = 32;
   localparam int WIDE_W   = 64;
   localparam int CAL_W    = 16;
   localparam int CSR_AW   = 3;
   localparam int DIV_LAT  = WIDE_W;   // one quotient bit per stage
   localparam int PIPE_LAT = 88;       // stages from input to output register

   // Register indexes of the configuration port
   localparam logic [CSR_AW-1:0] CSR_T1  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_T23 = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_P1  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_P23 = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_P45 = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_P67 = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_P89 = 3'd6;

   localparam logic [WIDE_W-1:0] T_FINE_OFFSET = 64'd128000;
   localparam logic [20:0]       P_FULL_SCALE  = 21'd1048576;
   localparam logic [WIDE_W-1:0] P_SCALE       = 64'd3125;
   localparam logic [WIDE_W-1:0] P_BIAS        = 64'd1 << 47;

   // Temperature results carried alongside the pressure path
   typedef struct packed {
      logic [WORD_W-1:0] temp;
      logic [WORD_W-1:0] tf;
   } temp_type;

   // Division sign and divide-by-zero flags
   typedef struct packed {
      logic neg;
      logic zero;
   } div_flag_type;

   function automatic logic [WIDE_W-1:0] sx16_64(input logic [CAL_W-1:0] v);
      return {{(WIDE_W-CAL_W){v[CAL_W-1]}}, v};
   endfunction

   function automatic logic [WORD_W-1:0] sx16_32(input logic [CAL_W-1:0] v);
      return {{(WORD_W-CAL_W){v[CAL_W-1]}}, v};
   endfunction

endpackage

### rtl/ptc_if.sv
// Interfaces: request and response channels of the compensation core.
`timescale 1ns / 1ps
interface ptc_req_if
   import ptc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ADC_W-1:0]  adc_temperature;
   logic [ADC_W-1:0]  adc_pressure;

   modport source (output valid, adc_temperature, adc_pressure, input ready);
   modport sink   (input valid, adc_temperature, adc_pressure, output ready);
endinterface

interface ptc_rsp_if
   import ptc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] temperature_centi;
   logic signed [WORD_W-1:0] fine_temperature;
   logic [WORD_W-1:0]        pressure_fixed;
   logic                     pressure_valid;

   modport source (output valid, temperature_centi, fine_temperature, pressure_fixed,
                   pressure_valid, input ready);
   modport sink   (input valid, temperature_centi, fine_temperature, pressure_fixed,
                   pressure_valid, output ready);
endinterface

### rtl/pressure_temperature_compensation_core.sv
// Top level: pipelined integer pressure and temperature compensation.
//
//  channel  direction  handshake      payload
//  req      in         valid/ready    adc_temperature, adc_pressure
//  rsp      out        valid/ready    temperature_centi, fine_temperature,
//                                     pressure_fixed, pressure_valid
//  csr      in         csr_we         csr_index, csr_wdata
//
// One item enters per cycle while the pipe is not stalled; each item passes 88 register
// stages on its way to the output register, most of them in the 64-stage divider.
// All stages advance together whenever the output register is empty or being taken,
// so a stall holds the whole pipe. Reset clears the valid bits and the calibration
// registers.
`timescale 1ns / 1ps
module pressure_temperature_compensation_core
   import ptc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ptc_req_if.sink           req,
   ptc_rsp_if.source         rsp,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [WORD_W-1:0] csr_wdata
);
   // Calibration registers
   logic [CAL_W-1:0]  cal_t1_ff, cal_p1_ff;
   logic [WORD_W-1:0] cal_t23_ff, cal_p23_ff, cal_p45_ff, cal_p67_ff, cal_p89_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t1_ff  <= '0;
         cal_t23_ff <= '0;
         cal_p1_ff  <= '0;
         cal_p23_ff <= '0;
         cal_p45_ff <= '0;
         cal_p67_ff <= '0;
         cal_p89_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_T1:  cal_t1_ff  <= csr_wdata[CAL_W-1:0];
            CSR_T23: cal_t23_ff <= csr_wdata;
            CSR_P1:  cal_p1_ff  <= csr_wdata[CAL_W-1:0];
            CSR_P23: cal_p23_ff <= csr_wdata;
            CSR_P45: cal_p45_ff <= csr_wdata;
            CSR_P67: cal_p67_ff <= csr_wdata;
            CSR_P89: cal_p89_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipe control: advance when the output register frees up
   logic en;
   logic vld_ff [PIPE_LAT];

   assign en        = !vld_ff[PIPE_LAT-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req.valid;
         for (int k = 1; k < PIPE_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // Temperature path, 32-bit wrap
   logic [WORD_W-1:0] a1_ff, b1_ff, m1_2_ff, bb2_ff, v1t3_ff, x3_ff;
   logic [WORD_W-1:0] v1t4_ff, m2_4_ff, tf5_ff, temp6_ff, tf6_ff;
   logic [WIDE_W-1:0] v6_ff;
   logic [WORD_W-1:0] t5_wide;

   assign t5_wide = tf5_ff * 32'd5 + 32'd128;

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= {15'd0, req.adc_temperature[ADC_W-1:3]} - {15'd0, cal_t1_ff, 1'b0};
         b1_ff   <= {16'd0, req.adc_temperature[ADC_W-1:4]} - {16'd0, cal_t1_ff};
         m1_2_ff <= a1_ff * sx16_32(cal_t23_ff[15:0]);
         bb2_ff  <= b1_ff * b1_ff;
         v1t3_ff <= $signed(m1_2_ff) >>> 11;
         x3_ff   <= $signed(bb2_ff) >>> 12;
         v1t4_ff <= v1t3_ff;
         m2_4_ff <= x3_ff * sx16_32(cal_t23_ff[31:16]);
         tf5_ff  <= v1t4_ff + WORD_W'($signed(m2_4_ff) >>> 14);
         temp6_ff <= $signed(t5_wide) >>> 8;
         tf6_ff   <= tf5_ff;
         v6_ff    <= {{(WIDE_W-WORD_W){tf5_ff[WORD_W-1]}}, tf5_ff} - T_FINE_OFFSET;
      end
   end

   // Carry temperature results and the pressure reading
   temp_type         tt_ff [PIPE_LAT-6];
   logic [ADC_W-1:0] ap_ff [11];

   always_ff @(posedge clock) begin
      if (en) begin
         tt_ff[0] <= '{temp: temp6_ff, tf: tf6_ff};
         for (int k = 1; k < PIPE_LAT-6; k++) tt_ff[k] <= tt_ff[k-1];
         ap_ff[0] <= req.adc_pressure;
         for (int k = 1; k < 11; k++) ap_ff[k] <= ap_ff[k-1];
      end
   end

   // First products of the offset fine temperature
   logic [WIDE_W-1:0] sq8, vp5_8, vp2_8;

   ptc_mul64 u_mul_sq  (.clock, .en, .a(v6_ff), .b(v6_ff), .p(sq8));
   ptc_mul64 u_mul_p5  (.clock, .en, .a(v6_ff), .b(sx16_64(cal_p45_ff[31:16])), .p(vp5_8));
   ptc_mul64 u_mul_p2  (.clock, .en, .a(v6_ff), .b(sx16_64(cal_p23_ff[15:0])), .p(vp2_8));

   // Square times P6 and P3; hold the shifted linear terms alongside
   logic [WIDE_W-1:0] sqp6_10, sqp3_10;
   logic [WIDE_W-1:0] s5_9_ff, s2_9_ff, s5_10_ff, s2_10_ff;

   ptc_mul64 u_mul_p6 (.clock, .en, .a(sq8), .b(sx16_64(cal_p67_ff[15:0])), .p(sqp6_10));
   ptc_mul64 u_mul_p3 (.clock, .en, .a(sq8), .b(sx16_64(cal_p23_ff[31:16])), .p(sqp3_10));

   // Combine terms, then prepare the divisor product and numerator
   logic [WIDE_W-1:0] var2_11_ff, var1_11_ff, x12_ff, n0_12_ff;
   logic [20:0]       pp11;

   assign pp11 = P_FULL_SCALE - {1'b0, ap_ff[10]};

   always_ff @(posedge clock) begin
      if (en) begin
         s5_9_ff    <= vp5_8 << 17;
         s2_9_ff    <= vp2_8 << 12;
         s5_10_ff   <= s5_9_ff;
         s2_10_ff   <= s2_9_ff;
         var2_11_ff <= sqp6_10 + s5_10_ff + (sx16_64(cal_p45_ff[15:0]) << 35);
         var1_11_ff <= WIDE_W'($signed(sqp3_10) >>> 8) + s2_10_ff;
         x12_ff     <= P_BIAS + var1_11_ff;
         n0_12_ff   <= ({43'd0, pp11} << 31) - var2_11_ff;
      end
   end

   logic [WIDE_W-1:0] dprod14, num14;

   ptc_mul64 u_mul_p1 (.clock, .en, .a(x12_ff), .b({48'd0, cal_p1_ff}), .p(dprod14));
   ptc_mul64 u_mul_sc (.clock, .en, .a(n0_12_ff), .b(P_SCALE), .p(num14));

   // Form divisor, then magnitudes and flags for the unsigned divider
   logic [WIDE_W-1:0] d15_ff, num15_ff, ma16_ff, mb16_ff;
   div_flag_type      fl16_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d15_ff   <= $signed(dprod14) >>> 33;
         num15_ff <= num14;
         ma16_ff  <= num15_ff[WIDE_W-1] ? -num15_ff : num15_ff;
         mb16_ff  <= d15_ff[WIDE_W-1] ? -d15_ff : d15_ff;
         fl16_ff  <= '{neg: num15_ff[WIDE_W-1] ^ d15_ff[WIDE_W-1], zero: d15_ff == '0};
      end
   end

   // Carry the division flags to the output
   div_flag_type fl_ff [71];

   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0] <= fl16_ff;
         for (int k = 1; k < 71; k++) fl_ff[k] <= fl_ff[k-1];
      end
   end

   logic [WIDE_W-1:0] q80;

   ptc_div64 u_div (.clock, .en, .dividend(ma16_ff), .divisor(mb16_ff), .quotient(q80));

   // Restore sign, then the second-order correction terms
   logic [WIDE_W-1:0] p81_ff, p82_ff, s82_ff;
   logic [WIDE_W-1:0] pd_ff [4];
   logic [WIDE_W-1:0] ss84, pp8_84, w1p86;
   logic [WIDE_W-1:0] w2_85_ff, w2_86_ff, sum87_ff;

   ptc_mul64 u_mul_ss (.clock, .en, .a(s82_ff), .b(s82_ff), .p(ss84));
   ptc_mul64 u_mul_p8 (.clock, .en, .a(p82_ff), .b(sx16_64(cal_p89_ff[15:0])), .p(pp8_84));
   ptc_mul64 u_mul_p9 (.clock, .en, .a(ss84), .b(sx16_64(cal_p89_ff[31:16])), .p(w1p86));

   always_ff @(posedge clock) begin
      if (en) begin
         p81_ff   <= fl_ff[63].neg ? -q80 : q80;
         p82_ff   <= p81_ff;
         s82_ff   <= $signed(p81_ff) >>> 13;
         pd_ff[0] <= p82_ff;
         for (int k = 1; k < 4; k++) pd_ff[k] <= pd_ff[k-1];
         w2_85_ff <= $signed(pp8_84) >>> 19;
         w2_86_ff <= w2_85_ff;
         sum87_ff <= pd_ff[3] + WIDE_W'($signed(w1p86) >>> 25) + w2_86_ff;
      end
   end

   // Output register
   logic [WIDE_W-1:0] pfin;
   logic [WORD_W-1:0] press88_ff;
   logic              pvalid88_ff;

   assign pfin = WIDE_W'($signed(sum87_ff) >>> 8) + (sx16_64(cal_p67_ff[31:16]) << 4);

   always_ff @(posedge clock) begin
      if (en) begin
         press88_ff  <= fl_ff[70].zero ? '0 : pfin[WORD_W-1:0];
         pvalid88_ff <= !fl_ff[70].zero;
      end
   end

   assign rsp.valid             = vld_ff[PIPE_LAT-1];
   assign rsp.temperature_centi = tt_ff[PIPE_LAT-7].temp;
   assign rsp.fine_temperature  = tt_ff[PIPE_LAT-7].tf;
   assign rsp.pressure_fixed    = press88_ff;
   assign rsp.pressure_valid    = pvalid88_ff;
endmodule

### rtl/ptc_mul64.sv
// Two-stage 64 x 64 multiplier that keeps the low 64 bits of the product.
`timescale 1ns / 1ps
module ptc_mul64
   import ptc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [WIDE_W-1:0] a,
   input  logic [WIDE_W-1:0] b,
   output logic [WIDE_W-1:0] p
);
   localparam int HW = WIDE_W / 2;

   logic [WIDE_W-1:0] ll_ff, ll_in;
   logic [HW-1:0]     lh_ff, lh_in, hl_ff, hl_in;
   logic [WIDE_W-1:0] p_ff, p_in;

   // Form 32 x 32 partial products; high-by-high falls outside 64 bits
   always_comb begin
      ll_in = {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[HW-1:0]};
      lh_in = a[HW-1:0] * b[WIDE_W-1:HW];
      hl_in = a[WIDE_W-1:HW] * b[HW-1:0];
   end

   // Sum the partial products
   always_comb begin
      p_in = ll_ff + {lh_ff + hl_ff, {HW{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;
endmodule

### rtl/ptc_div64.sv
// Pipelined restoring divider: 64-bit unsigned quotient, one bit per stage.
`timescale 1ns / 1ps
module ptc_div64
   import ptc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [WIDE_W-1:0] dividend,
   input  logic [WIDE_W-1:0] divisor,
   output logic [WIDE_W-1:0] quotient
);
   logic [WIDE_W-1:0] rem_ff [DIV_LAT];
   logic [WIDE_W-1:0] rem_in [DIV_LAT];
   logic [WIDE_W-1:0] dvd_ff [DIV_LAT];
   logic [WIDE_W-1:0] dvd_in [DIV_LAT];
   logic [WIDE_W-1:0] dsr_ff [DIV_LAT];
   logic [WIDE_W-1:0] dsr_in [DIV_LAT];

   // Shift in one dividend bit, subtract where it fits, shift in the quotient bit
   always_comb begin
      logic [WIDE_W-1:0] r_prev;
      logic [WIDE_W-1:0] q_prev;
      logic [WIDE_W:0]   trial;
      logic [WIDE_W:0]   diff;
      for (int k = 0; k < DIV_LAT; k++) begin
         if (k == 0) begin
            r_prev    = '0;
            q_prev    = dividend;
            dsr_in[k] = divisor;
         end else begin
            r_prev    = rem_ff[k-1];
            q_prev    = dvd_ff[k-1];
            dsr_in[k] = dsr_ff[k-1];
         end
         trial = {r_prev, q_prev[WIDE_W-1]};
         diff  = trial - {1'b0, dsr_in[k]};
         if (!diff[WIDE_W]) begin
            rem_in[k] = diff[WIDE_W-1:0];
            dvd_in[k] = {q_prev[WIDE_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[WIDE_W-1:0];
            dvd_in[k] = {q_prev[WIDE_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            rem_ff[k] <= rem_in[k];
            dvd_ff[k] <= dvd_in[k];
            dsr_ff[k] <= dsr_in[k];
         end
      end
   end

   assign quotient = dvd_ff[DIV_LAT-1];
endmodule
